### rtl/jfhp_pkg.sv
package jfhp_pkg;

    localparam logic [3:0] PH_SOI0  = 4'd0;
    localparam logic [3:0] PH_SOI1  = 4'd1;
    localparam logic [3:0] PH_MARK0 = 4'd2;
    localparam logic [3:0] PH_MARK1 = 4'd3;
    localparam logic [3:0] PH_LEN0  = 4'd4;
    localparam logic [3:0] PH_LEN1  = 4'd5;
    localparam logic [3:0] PH_SKIP  = 4'd6;
    localparam logic [3:0] PH_FRAME = 4'd7;
    localparam logic [3:0] PH_DONE  = 4'd8;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_NOFRAME   = 2'd3;

    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] SOI_CODE      = 8'hD8;

    localparam logic [2:0] FLD_HEIGHT_HI = 3'd3;
    localparam logic [2:0] FLD_HEIGHT_LO = 3'd4;
    localparam logic [2:0] FLD_WIDTH_HI  = 3'd5;
    localparam logic [2:0] FLD_WIDTH_LO  = 3'd6;
    localparam logic [2:0] FLD_COUNT     = 3'd7;

    typedef struct packed {
        logic [3:0]  phase;
        logic [15:0] skip_remaining;
        logic [2:0]  field_index;
        logic [15:0] height_hold;
        logic [15:0] width_hold;
    } t_parse_state;

    typedef struct packed {
        logic [15:0] image_height;
        logic [15:0] image_width;
        logic [7:0]  component_count;
        logic [1:0]  parse_status;
    } t_result;

    localparam t_parse_state STATE_RESET = '{
        phase:          PH_SOI0,
        skip_remaining: 16'd0,
        field_index:    3'd0,
        height_hold:    16'd0,
        width_hold:     16'd0
    };

    function automatic logic is_frame_code(input logic [7:0] code);
        return code inside {8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC5, 8'hC6, 8'hC7,
                            8'hC9, 8'hCA, 8'hCB, 8'hCD, 8'hCE, 8'hCF};
    endfunction

endpackage

### rtl/jpeg_frame_header_parser_top.sv
// JPEG frame header parser. Feed the file one byte per item with the final
// byte flagged by i_last_byte; every stream yields exactly one result item:
// height, width and component count of the first start-of-frame segment
// with status ok, or zeros with status invalid (bad start marker, missing
// FF where a marker starts, segment length below 2), truncated (stream
// ends after a marker code, inside a length or a frame header) or no
// frame header. Bytes after the result are swallowed up to the last byte,
// and the next byte starts a new stream. Throughput is one byte per cycle:
// each byte passes through one combinational step of the segment walker
// into the state registers. A two-entry output stage (result register plus
// skid) keeps input flowing while a result waits; input stalls only when
// both entries are full.
module jpeg_frame_header_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_image_height,
    output logic [15:0] o_image_width,
    output logic [7:0]  o_component_count,
    output logic [1:0]  o_parse_status
);

    jfhp_pkg::t_parse_state r_state;
    jfhp_pkg::t_parse_state n_state;
    jfhp_pkg::t_result      step_result;
    jfhp_pkg::t_result      out_result;
    logic                   step_valid;
    logic                   in_accept;
    logic                   buf_full;

    // stall input only when both output entries hold a result
    assign o_in_ready = !buf_full;
    assign in_accept  = i_in_valid && o_in_ready;

    jfhp_step u_step (
        .i_state        (r_state),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_state        (n_state),
        .o_result_valid (step_valid),
        .o_result       (step_result)
    );

    // advance the walker on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jfhp_pkg::STATE_RESET;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    jfhp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept && step_valid),
        .i_data  (step_result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_result)
    );

    assign o_image_height    = out_result.image_height;
    assign o_image_width     = out_result.image_width;
    assign o_component_count = out_result.component_count;
    assign o_parse_status    = out_result.parse_status;

`ifndef SYNTHESIS
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_last_byte) |=> (r_state.phase == jfhp_pkg::PH_SOI0))
        else $error("walker not rearmed after last byte");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_last_byte && r_state.phase == jfhp_pkg::PH_DONE)
        |-> !step_valid)
        else $error("result produced after stream already reported");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_parse_status != jfhp_pkg::ST_OK)
        |-> (o_image_height == 16'd0 && o_image_width == 16'd0
             && o_component_count == 8'd0))
        else $error("nonzero frame fields on failed parse");
`endif

endmodule

### rtl/jfhp_step.sv
module jfhp_step (
    input  jfhp_pkg::t_parse_state i_state,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_byte,
    output jfhp_pkg::t_parse_state o_state,
    output logic                   o_result_valid,
    output jfhp_pkg::t_result      o_result
);

    logic [15:0] seg_len;
    logic [1:0]  end_status;

    assign seg_len = {i_state.skip_remaining[7:0], i_data_byte};

    always_comb begin
        o_state        = i_state;
        o_result_valid = 1'b0;
        o_result       = '0;
        end_status     = jfhp_pkg::ST_NOFRAME;

        case (i_state.phase)
            jfhp_pkg::PH_SOI0: begin
                if (i_data_byte != jfhp_pkg::MARKER_PREFIX || i_last_byte) begin
                    o_result_valid = 1'b1;
                    o_result.parse_status = jfhp_pkg::ST_INVALID;
                end else begin
                    o_state.phase = jfhp_pkg::PH_SOI1;
                end
            end
            jfhp_pkg::PH_SOI1: begin
                if (i_data_byte != jfhp_pkg::SOI_CODE) begin
                    o_result_valid = 1'b1;
                    o_result.parse_status = jfhp_pkg::ST_INVALID;
                end else begin
                    o_state.phase = jfhp_pkg::PH_MARK0;
                end
            end
            jfhp_pkg::PH_MARK0: begin
                if (i_data_byte != jfhp_pkg::MARKER_PREFIX) begin
                    o_result_valid = 1'b1;
                    o_result.parse_status = jfhp_pkg::ST_INVALID;
                end else begin
                    o_state.phase = jfhp_pkg::PH_MARK1;
                end
            end
            jfhp_pkg::PH_MARK1: begin
                end_status = jfhp_pkg::ST_TRUNCATED;
                if (jfhp_pkg::is_frame_code(i_data_byte)) begin
                    o_state.field_index = 3'd0;
                    o_state.phase       = jfhp_pkg::PH_FRAME;
                end else begin
                    o_state.phase = jfhp_pkg::PH_LEN0;
                end
            end
            jfhp_pkg::PH_LEN0: begin
                end_status             = jfhp_pkg::ST_TRUNCATED;
                o_state.skip_remaining = {8'd0, i_data_byte};
                o_state.phase          = jfhp_pkg::PH_LEN1;
            end
            jfhp_pkg::PH_LEN1: begin
                if (seg_len < 16'd2) begin
                    o_result_valid = 1'b1;
                    o_result.parse_status = jfhp_pkg::ST_INVALID;
                end else begin
                    o_state.skip_remaining = seg_len - 16'd2;
                    o_state.phase = (seg_len == 16'd2) ? jfhp_pkg::PH_MARK0
                                                       : jfhp_pkg::PH_SKIP;
                end
            end
            jfhp_pkg::PH_SKIP: begin
                o_state.skip_remaining = i_state.skip_remaining - 16'd1;
                if (i_state.skip_remaining == 16'd1) begin
                    o_state.phase = jfhp_pkg::PH_MARK0;
                end
            end
            jfhp_pkg::PH_FRAME: begin
                end_status = jfhp_pkg::ST_TRUNCATED;
                case (i_state.field_index)
                    jfhp_pkg::FLD_HEIGHT_HI: o_state.height_hold = {i_data_byte, 8'd0};
                    jfhp_pkg::FLD_HEIGHT_LO: o_state.height_hold[7:0] = i_data_byte;
                    jfhp_pkg::FLD_WIDTH_HI:  o_state.width_hold = {i_data_byte, 8'd0};
                    jfhp_pkg::FLD_WIDTH_LO:  o_state.width_hold[7:0] = i_data_byte;
                    jfhp_pkg::FLD_COUNT: begin
                        o_result_valid           = 1'b1;
                        o_result.image_height    = i_state.height_hold;
                        o_result.image_width     = i_state.width_hold;
                        o_result.component_count = i_data_byte;
                        o_result.parse_status    = jfhp_pkg::ST_OK;
                    end
                    default: ;
                endcase
                o_state.field_index = i_state.field_index + 3'd1;
            end
            default: ;
        endcase

        if (o_result_valid) begin
            o_state.phase = jfhp_pkg::PH_DONE;
        end

        // end of stream: report why no frame came, then rearm
        if (i_last_byte) begin
            if (!o_result_valid && i_state.phase != jfhp_pkg::PH_DONE) begin
                o_result_valid        = 1'b1;
                o_result              = '0;
                o_result.parse_status = end_status;
            end
            o_state = jfhp_pkg::STATE_RESET;
        end
    end

endmodule

### rtl/jfhp_out_buf.sv
module jfhp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  jfhp_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output jfhp_pkg::t_result o_data
);

    logic              r_out_valid;
    logic              r_skid_valid;
    jfhp_pkg::t_result r_out;
    jfhp_pkg::t_result r_skid;
    logic              free;

    assign free    = !r_out_valid || i_ready;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule
